/* hdl/dgos_pkg.sv */
// Shared types and constants for the depth grid obstacle steering block.
`default_nettype none
package dgos_pkg;

  localparam int DIST_W  = 12;
  localparam int MINPX_W = 4;
  localparam int SPEED_W = 10;
  localparam int TURN_W  = 12;
  localparam int VEL_W   = 11;
  localparam int RATE_W  = 13;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 12;

  localparam logic [CFG_AW-1:0] REG_OBSTACLE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_PIX  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_TIE      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SPEED    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TURN     = 3'd4;

  localparam logic [DIST_W-1:0]  RST_OBSTACLE = 12'd170;
  localparam logic [MINPX_W-1:0] RST_MIN_PIX  = 4'd2;
  localparam logic [DIST_W-1:0]  RST_TIE      = 12'd20;
  localparam logic [SPEED_W-1:0] RST_SPEED    = 10'd250;
  localparam logic [TURN_W-1:0]  RST_TURN     = 12'd2000;

  typedef struct packed {
    logic acc;   // accumulate the accepted zone
    logic mul;   // form threshold and cross products
    logic cmp;   // compare and register decision flags
    logic fin;   // pick steering case, emit word, clear frame
  } dgos_cmd_t;

endpackage
`default_nettype wire

/* hdl/dgos_ctrl.sv */
// Controller state machine: zone intake and frame-end decision sequence.
`default_nettype none
module dgos_ctrl
  import dgos_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic frame_end,
  output logic      busy,
  output dgos_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start && frame_end) state_next = S_MUL;
      S_MUL:  state_next = S_CMP;
      S_CMP:  state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy    = (state != S_IDLE);
  assign cmd.acc = (state == S_IDLE) && start;
  assign cmd.mul = (state == S_MUL);
  assign cmd.cmp = (state == S_CMP);
  assign cmd.fin = (state == S_FIN);

endmodule
`default_nettype wire

/* hdl/dgos_dp.sv */
// Datapath: config registers, region accumulators, exact mean compares, steering.
`default_nettype none
module dgos_dp
  import dgos_pkg::*;
#(
  parameter int GRID_WIDTH  = 4,
  parameter int GRID_HEIGHT = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dgos_cmd_t                cmd,
  input  wire logic [DIST_W-1:0]        zone_dist,
  input  wire logic                     frame_end,
  input  wire logic                     treasure_found,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_AW-1:0]        cfg_addr,
  input  wire logic [CFG_DW-1:0]        cfg_data,
  output logic                          done,
  output logic signed [VEL_W-1:0]       velocity_mm_s,
  output logic signed [RATE_W-1:0]      turn_rate,
  output logic                          forced_turn
);

  localparam int TOTAL = GRID_WIDTH * GRID_HEIGHT;
  localparam int CPIX  = (GRID_HEIGHT - 2) * GRID_WIDTH;
  localparam int ZCW   = $clog2(TOTAL + 1);
  localparam int SCW   = $clog2(GRID_WIDTH + 1);
  localparam int CCW   = $clog2(CPIX + 1);
  localparam int SSW   = DIST_W + SCW;
  localparam int CSW   = DIST_W + CCW;
  localparam int XW    = SSW + SCW;
  localparam int TLW   = DIST_W + SCW;
  localparam int LIMW  = TLW + SCW;
  localparam int DW    = (XW > LIMW) ? XW : LIMW;
  localparam int SVW   = (SCW > MINPX_W) ? SCW : MINPX_W;
  localparam int CVW   = (CCW > MINPX_W) ? CCW : MINPX_W;
  localparam int RIGHT_START = (GRID_HEIGHT - 1) * GRID_WIDTH;

  // configuration
  logic [DIST_W-1:0]  obstacle_thresh;
  logic [MINPX_W-1:0] min_valid_pixels;
  logic [DIST_W-1:0]  tie_margin_mm;
  logic [SPEED_W-1:0] forward_speed_mm_s;
  logic [TURN_W-1:0]  turn_rate_mrad_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_thresh      <= RST_OBSTACLE;
      min_valid_pixels     <= RST_MIN_PIX;
      tie_margin_mm        <= RST_TIE;
      forward_speed_mm_s   <= RST_SPEED;
      turn_rate_mrad_s     <= RST_TURN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OBSTACLE: obstacle_thresh      <= cfg_data;
        REG_MIN_PIX:  min_valid_pixels     <= cfg_data[MINPX_W-1:0];
        REG_TIE:      tie_margin_mm        <= cfg_data;
        REG_SPEED:    forward_speed_mm_s   <= cfg_data[SPEED_W-1:0];
        REG_TURN:     turn_rate_mrad_s     <= cfg_data[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // accumulation
  logic [ZCW-1:0] zone_counter;
  logic [SSW-1:0] left_sum, right_sum;
  logic [CSW-1:0] centre_sum;
  logic [SCW-1:0] left_count, right_count;
  logic [CCW-1:0] centre_count;
  logic           treasure;

  always_ff @(posedge clk) begin
    if (rst || cmd.fin) begin
      zone_counter <= '0;
      left_sum     <= '0;
      left_count   <= '0;
      centre_sum   <= '0;
      centre_count <= '0;
      right_sum    <= '0;
      right_count  <= '0;
    end else if (cmd.acc && (zone_counter < ZCW'(TOTAL))) begin
      zone_counter <= zone_counter + ZCW'(1);
      if (zone_dist != '0) begin
        if (zone_counter < ZCW'(GRID_WIDTH)) begin
          left_sum   <= left_sum + SSW'(zone_dist);
          left_count <= left_count + SCW'(1);
        end else if (zone_counter >= ZCW'(RIGHT_START)) begin
          right_sum   <= right_sum + SSW'(zone_dist);
          right_count <= right_count + SCW'(1);
        end else begin
          centre_sum   <= centre_sum + CSW'(zone_dist);
          centre_count <= centre_count + CCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && frame_end) treasure <= treasure_found;
  end

  // products
  logic [SSW-1:0] thr_l, thr_r;
  logic [CSW-1:0] thr_c;
  logic [XW-1:0]  cross_a, cross_b;
  logic [TLW-1:0] tie_l;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      thr_l   <= SSW'(obstacle_thresh * left_count);
      thr_r   <= SSW'(obstacle_thresh * right_count);
      thr_c   <= CSW'(obstacle_thresh * centre_count);
      cross_a <= XW'(left_sum * right_count);
      cross_b <= XW'(right_sum * left_count);
      tie_l   <= TLW'(tie_margin_mm * left_count);
    end
  end

  // compares
  logic          val_l, val_r, val_c;
  logic [DW-1:0] diff;
  logic [DW-1:0] lim;
  logic          obs_l, obs_c, obs_r, a_ge_b, side_ge, tie;

  assign val_l = (left_count != '0) && (SVW'(left_count) >= SVW'(min_valid_pixels));
  assign val_r = (right_count != '0) && (SVW'(right_count) >= SVW'(min_valid_pixels));
  assign val_c = (centre_count != '0) && (CVW'(centre_count) >= CVW'(min_valid_pixels));
  assign diff  = (cross_a >= cross_b) ? DW'(cross_a - cross_b) : DW'(cross_b - cross_a);
  assign lim   = DW'(tie_l * right_count);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      obs_l   <= val_l && (left_sum < thr_l);
      obs_r   <= val_r && (right_sum < thr_r);
      obs_c   <= val_c && (centre_sum < thr_c);
      a_ge_b  <= (cross_a >= cross_b);
      side_ge <= !val_l || (val_r && (cross_a >= cross_b));
      tie     <= (diff < lim);
    end
  end

  // steering case
  logic signed [VEL_W-1:0]  fwd_full, fwd_half, vel_next;
  logic signed [RATE_W-1:0] trn, rate_next;
  logic                     forced_next;

  assign fwd_full = VEL_W'({1'b0, forward_speed_mm_s});
  assign fwd_half = VEL_W'({2'b00, forward_speed_mm_s[SPEED_W-1:1]});
  assign trn      = RATE_W'({1'b0, turn_rate_mrad_s});

  always_comb begin
    vel_next    = '0;
    rate_next   = '0;
    forced_next = 1'b0;
    if (!obs_l && !obs_c && !obs_r) begin
      vel_next = -fwd_full;
    end else if (obs_l && !obs_r) begin
      vel_next  = obs_c ? '0 : -fwd_half;
      rate_next = trn;
    end else if (obs_r && !obs_l) begin
      vel_next  = obs_c ? '0 : -fwd_half;
      rate_next = -trn;
    end else if (!obs_l && !obs_r) begin
      rate_next = side_ge ? trn : -trn;
    end else if (tie) begin
      rate_next   = treasure ? trn : -trn;
      forced_next = 1'b1;
    end else begin
      rate_next = a_ge_b ? trn : -trn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      velocity_mm_s <= vel_next;
      turn_rate     <= rate_next;
      forced_turn   <= forced_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/depth_grid_obstacle_steering.sv */
// Top level of the depth grid obstacle steering block.
//
//   channel  | handshake         | word
//   ---------+-------------------+-----------------------------------------
//   zone in  | start & !busy     | zone_dist, frame_end, treasure_found
//   result   | done (one cycle)  | velocity_mm_s, turn_rate, forced_turn
//   config   | cfg_we            | cfg_addr, cfg_data
//
// One zone is taken per cycle; busy stays low while a frame is streaming.
// A zone with frame_end raises busy through the product, compare and decision
// steps; done is registered from the decision step and rises in the cycle after it.
// Synchronous reset restores register defaults and clears the frame.
// done is a strobe: the receiver cannot stall it.
`default_nettype none
module depth_grid_obstacle_steering
  import dgos_pkg::*;
#(
  parameter int GRID_WIDTH  = 4,
  parameter int GRID_HEIGHT = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [DIST_W-1:0]    zone_dist,
  input  wire logic                 frame_end,
  input  wire logic                 treasure_found,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_AW-1:0]    cfg_addr,
  input  wire logic [CFG_DW-1:0]    cfg_data,
  output logic                      done,
  output logic signed [VEL_W-1:0]   velocity_mm_s,
  output logic signed [RATE_W-1:0]  turn_rate,
  output logic                      forced_turn
);

  dgos_cmd_t cmd;

  dgos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .frame_end (frame_end),
    .busy      (busy),
    .cmd       (cmd)
  );

  dgos_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .zone_dist      (zone_dist),
    .frame_end      (frame_end),
    .treasure_found (treasure_found),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .done           (done),
    .velocity_mm_s  (velocity_mm_s),
    .turn_rate      (turn_rate),
    .forced_turn    (forced_turn)
  );

endmodule
`default_nettype wire

/* tb/depth_grid_obstacle_steering_tb.sv */
// Testbench for depth_grid_obstacle_steering: directed and random framed zone streams, predicted steering words.
`default_nettype none
module depth_grid_obstacle_steering_tb;
  import dgos_pkg::*;

  localparam int GRID_W = 4;
  localparam int GRID_H = 4;
  localparam int GRID_ZONES = GRID_W * GRID_H;
  localparam int REG_COUNT = 5;
  localparam int PHASES = 11;
  localparam int PHASE_ZONES = 100;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic signed [VEL_W-1:0]  vel;
    logic signed [RATE_W-1:0] rate;
    logic                     forced;
  } steer_word_t;

  class steering_scoreboard;
    logic [DIST_W-1:0]  obst_mm;
    logic [MINPX_W-1:0] min_pix;
    logic [DIST_W-1:0]  tie_mm;
    logic [SPEED_W-1:0] speed;
    logic [TURN_W-1:0]  turn;
    int unsigned        zone_idx;
    longint             sum_l, sum_c, sum_r;
    longint             cnt_l, cnt_c, cnt_r;
    steer_word_t        pending_words[$];
    int                 mismatches;

    function new();
      mismatches = 0;
      reset_state();
    endfunction

    function void clear_frame();
      zone_idx = 0;
      sum_l = 0; sum_c = 0; sum_r = 0;
      cnt_l = 0; cnt_c = 0; cnt_r = 0;
    endfunction

    function void reset_state();
      obst_mm = RST_OBSTACLE;
      min_pix = RST_MIN_PIX;
      tie_mm  = RST_TIE;
      speed   = RST_SPEED;
      turn    = RST_TURN;
      clear_frame();
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_OBSTACLE: obst_mm = data[DIST_W-1:0];
        REG_MIN_PIX:  min_pix = data[MINPX_W-1:0];
        REG_TIE:      tie_mm  = data[DIST_W-1:0];
        REG_SPEED:    speed   = data[SPEED_W-1:0];
        REG_TURN:     turn    = data[TURN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit region_ok(longint c);
      return c >= 1 && c >= longint'(min_pix);
    endfunction

    function bit blocked(longint s, longint c);
      return region_ok(c) && s < longint'(obst_mm) * c;
    endfunction

    function void note_zone(logic [DIST_W-1:0] d, logic fe, logic tr);
      steer_word_t w;
      longint fwd, trn, v, r, a, b, diff, lim;
      bit ol, oc, orr, left_ge;
      int unsigned row;
      if (zone_idx < GRID_ZONES) begin
        row = zone_idx / GRID_W;
        if (d != 0) begin
          if (row == 0) begin
            sum_l += d; cnt_l++;
          end else if (row == GRID_H - 1) begin
            sum_r += d; cnt_r++;
          end else begin
            sum_c += d; cnt_c++;
          end
        end
        zone_idx++;
      end
      if (!fe) return;
      ol  = blocked(sum_l, cnt_l);
      oc  = blocked(sum_c, cnt_c);
      orr = blocked(sum_r, cnt_r);
      fwd = speed;
      trn = turn;
      v = 0;
      r = 0;
      w.forced = 1'b0;
      if (!ol && !oc && !orr) begin
        v = -fwd;
      end else if (ol && !orr) begin
        v = oc ? 0 : -(fwd / 2);
        r = trn;
      end else if (orr && !ol) begin
        v = oc ? 0 : -(fwd / 2);
        r = -trn;
      end else if (oc && !ol && !orr) begin
        if (!region_ok(cnt_l)) left_ge = 1'b1;
        else if (!region_ok(cnt_r)) left_ge = 1'b0;
        else left_ge = sum_l * cnt_r >= sum_r * cnt_l;
        r = left_ge ? trn : -trn;
      end else begin
        a = sum_l * cnt_r;
        b = sum_r * cnt_l;
        diff = (a >= b) ? a - b : b - a;
        lim = longint'(tie_mm) * cnt_l * cnt_r;
        if (diff < lim) begin
          r = tr ? trn : -trn;
          w.forced = 1'b1;
        end else begin
          r = (a >= b) ? trn : -trn;
        end
      end
      w.vel  = VEL_W'(v);
      w.rate = RATE_W'(r);
      pending_words.push_back(w);
      clear_frame();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check(logic signed [VEL_W-1:0] vel, logic signed [RATE_W-1:0] rate,
                        logic forced);
      steer_word_t w;
      if (pending_words.size() == 0) begin
        flag($sformatf("unexpected word: vel %0d rate %0d forced %0b", vel, rate, forced));
        return;
      end
      w = pending_words.pop_front();
      if (vel !== w.vel)
        flag($sformatf("velocity: expected %0d, got %0d", w.vel, vel));
      if (rate !== w.rate)
        flag($sformatf("turn rate: expected %0d, got %0d", w.rate, rate));
      if (forced !== w.forced)
        flag($sformatf("forced turn: expected %0b, got %0b", w.forced, forced));
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [DIST_W-1:0]        zone_dist = '0;
  logic                     frame_end = 1'b0;
  logic                     treasure_found = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_AW-1:0]        cfg_addr = '0;
  logic [CFG_DW-1:0]        cfg_data = '0;
  logic                     done;
  logic signed [VEL_W-1:0]  velocity_mm_s;
  logic signed [RATE_W-1:0] turn_rate;
  logic                     forced_turn;

  steering_scoreboard sb;
  bit no_idle = 1'b0;
  int zones_sent = 0;

  depth_grid_obstacle_steering #(
    .GRID_WIDTH(GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .zone_dist(zone_dist),
    .frame_end(frame_end),
    .treasure_found(treasure_found),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .done(done),
    .velocity_mm_s(velocity_mm_s),
    .turn_rate(turn_rate),
    .forced_turn(forced_turn)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      sb.reset_state();
    end else begin
      if (cfg_we) sb.write_reg(cfg_addr, cfg_data);
      if (start && !busy) sb.note_zone(zone_dist, frame_end, treasure_found);
      if (done) sb.check(velocity_mm_s, turn_rate, forced_turn);
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int clamp_dist(int x);
    if (x < 0) return 0;
    if (x > 4095) return 4095;
    return x;
  endfunction

  task automatic send_zone(input logic [DIST_W-1:0] d, input logic fe, input logic tr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    zone_dist      <= d;
    frame_end      <= fe;
    treasure_found <= tr;
    do @(posedge clk); while (busy);
    zones_sent++;
  endtask

  task automatic drain(input int extra);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] dt);
    cfg_we   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= dt;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_phase(input int p);
    if (p == 0) begin
      write_reg(REG_OBSTACLE, '0);
      write_reg(REG_MIN_PIX, '0);
      write_reg(REG_TIE, '0);
      write_reg(REG_SPEED, '0);
      write_reg(REG_TURN, '0);
    end else if (p == 1) begin
      write_reg(REG_OBSTACLE, '1);
      write_reg(REG_MIN_PIX, '1);
      write_reg(REG_TIE, '1);
      write_reg(REG_SPEED, '1);
      write_reg(REG_TURN, '1);
    end else if (p == 2) begin
      write_reg(REG_OBSTACLE, CFG_DW'(RST_OBSTACLE));
      write_reg(REG_MIN_PIX, CFG_DW'(RST_MIN_PIX));
      write_reg(REG_TIE, CFG_DW'(RST_TIE));
      write_reg(REG_SPEED, CFG_DW'(RST_SPEED));
      write_reg(REG_TURN, CFG_DW'(RST_TURN));
    end else begin
      write_reg(REG_OBSTACLE, ($urandom_range(0, 1) == 0) ? CFG_DW'($urandom_range(40, 600))
                                                           : CFG_DW'($urandom));
      write_reg(REG_MIN_PIX, ($urandom_range(0, 9) < 7) ? CFG_DW'($urandom_range(1, 8))
                                                         : CFG_DW'($urandom));
      write_reg(REG_TIE, ($urandom_range(0, 1) == 0) ? CFG_DW'($urandom_range(0, 60))
                                                      : CFG_DW'($urandom));
      write_reg(REG_SPEED, CFG_DW'($urandom));
      write_reg(REG_TURN, CFG_DW'($urandom));
    end
    write_reg(CFG_AW'($urandom_range(REG_COUNT, (1 << CFG_AW) - 1)), CFG_DW'($urandom));
  endtask

  // One frame: per-region base distance, jitter and dropout; some short, long or pure noise.
  task automatic send_frame();
    int base[3];
    int jit[3];
    int zpct[3];
    int r, len, i, rg, v, obst;
    bit noise;
    obst = sb.obst_mm;
    noise = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 70) len = GRID_ZONES;
    else if (r < 80) len = $urandom_range(1, GRID_ZONES - 1);
    else if (r < 90) len = $urandom_range(GRID_ZONES + 1, GRID_ZONES + 8);
    else begin
      len = $urandom_range(1, GRID_ZONES + 4);
      noise = 1'b1;
    end
    for (rg = 0; rg < 3; rg++) begin
      r = $urandom_range(0, 9);
      if (r < 4) base[rg] = (obst > 0) ? $urandom_range(0, obst - 1) : 0;
      else if (r < 7) base[rg] = $urandom_range(obst, 4095);
      else if (r < 8) base[rg] = clamp_dist(obst + $urandom_range(0, 4) - 2);
      else if (r < 9) base[rg] = 0;
      else base[rg] = $urandom_range(0, 4095);
      jit[rg] = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 8);
      r = $urandom_range(0, 2);
      zpct[rg] = (r == 0) ? 0 : (r == 1) ? 10 : 40;
    end
    if ($urandom_range(0, 2) == 0) begin
      // cornered with sides near one another
      base[0] = (obst > 0) ? $urandom_range(0, obst - 1) : 0;
      base[2] = clamp_dist(base[0] + $urandom_range(0, sb.tie_mm + sb.tie_mm / 2 + 2));
      zpct[0] = 0;
      zpct[2] = 0;
    end
    for (i = 0; i < len; i++) begin
      if (i / GRID_W == 0) rg = 0;
      else if (i / GRID_W == GRID_H - 1) rg = 2;
      else rg = 1;
      if (noise || i >= GRID_ZONES) v = $urandom_range(0, 4095);
      else if ($urandom_range(0, 99) < zpct[rg]) v = 0;
      else v = clamp_dist(base[rg] + $urandom_range(0, 2 * jit[rg]) - jit[rg]);
      send_zone(DIST_W'(v), i == len - 1, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int p, phase_start, errs;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    no_idle = 1'b1;
    send_zone('1, 1'b1, 1'b0);
    send_zone('0, 1'b1, 1'b1);
    drain(SETTLE_CYCLES);
    write_reg(REG_MIN_PIX, '0);
    write_reg(REG_SPEED, CFG_DW'(251));
    send_zone(DIST_W'(1), 1'b1, 1'b0);
    send_zone('0, 1'b0, 1'b0);
    send_zone('0, 1'b0, 1'b1);
    send_zone('0, 1'b0, 1'b0);
    send_zone('0, 1'b0, 1'b1);
    send_zone(DIST_W'(5), 1'b1, 1'b1);
    drain(SETTLE_CYCLES);

    for (p = 0; p < PHASES; p++) begin
      set_phase(p);
      no_idle = (p % 4 == 3);
      phase_start = zones_sent;
      while (zones_sent - phase_start < PHASE_ZONES) begin
        if ($urandom_range(0, 19) == 0) drain(0);
        if (p % 4 != 3 && $urandom_range(0, 9) == 0) no_idle = !no_idle;
        send_frame();
      end
      drain(SETTLE_CYCLES);
    end

    drain(SETTLE_CYCLES);
    errs = sb.mismatches + sb.pending();
    if (errs == 0) $display("depth_grid_obstacle_steering_tb: clean");
    else $display("depth_grid_obstacle_steering_tb: errors");
    $finish;
  end

  initial begin
    #400000;
    $display("depth_grid_obstacle_steering_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
